// File: design/agr_pkg.sv
// ---------------------------------------------------------------------------
// agr_pkg
// Shared constants for the array gcd reducer.
// ---------------------------------------------------------------------------
package agr_pkg;

    // Default width of an array element and of the gcd result
    localparam int unsigned VALUE_WIDTH = 31;

endpackage

// File: design/agr_if.sv
// ---------------------------------------------------------------------------
// agr_if
// Valid/ready channels of the array gcd reducer: element input, gcd output.
// ---------------------------------------------------------------------------
interface agr_in_if #(
    parameter int unsigned VALUE_WIDTH = agr_pkg::VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface agr_out_if #(
    parameter int unsigned VALUE_WIDTH = agr_pkg::VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] gcd_value;

    modport source (output valid, output gcd_value, input ready);
    modport sink   (input valid, input gcd_value, output ready);
endinterface

// File: design/array_gcd_reducer.sv
// ---------------------------------------------------------------------------
// array_gcd_reducer
// Folds a stream of array elements into their greatest common divisor.
// ---------------------------------------------------------------------------
// Usage:
//   i_in  : one element per transaction (value, last). The running gcd
//           starts at zero; each element is folded in by binary gcd.
//   o_res : one transaction per array, after the element marked last,
//           carrying the gcd of all elements of that array.
// Operation:
//   Each element is processed alone; i_in.ready is high only between
//   elements. The difference of the two operands is formed by a bit-serial
//   subtractor over the full operand width; trailing zeros are shifted out
//   one bit a cycle. An element skips the subtract passes when either
//   operand is zero; otherwise passes repeat until the difference is zero.
// Reset: clears the running gcd to zero and empties the output register.
// Stall: the result waits in an output register; the next array is taken
//   in at once and only its last element waits while o_res is still full.
// ---------------------------------------------------------------------------
module array_gcd_reducer #(
    parameter int unsigned VALUE_WIDTH = agr_pkg::VALUE_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    agr_in_if.sink    i_in,
    agr_out_if.source o_res
);
    import agr_pkg::*;

    localparam int unsigned CW = $clog2(VALUE_WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_WIDTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZERO,
        ST_TWOS,
        ST_STRIPA,
        ST_STRIPB,
        ST_SUB,
        ST_SCALE,
        ST_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_run, n_run;
    logic [VALUE_WIDTH-1:0] r_a, n_a;
    logic [VALUE_WIDTH-1:0] r_b, n_b;
    logic [VALUE_WIDTH-1:0] r_d1, n_d1;
    logic [VALUE_WIDTH-1:0] r_d2, n_d2;
    logic [VALUE_WIDTH-1:0] r_out, n_out;
    logic                   r_out_valid, n_out_valid;
    logic                   r_last, n_last;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [CW-1:0]          r_k, n_k;
    logic                   r_br1, n_br1;
    logic                   r_br2, n_br2;
    logic                   r_nz, n_nz;

    // serial subtractor bits: d1 = a - b, d2 = b - a
    logic s_dbit1, s_dbit2, s_bor1, s_bor2, s_eq;

    assign s_eq    = ~(r_a[0] ^ r_b[0]);
    assign s_dbit1 = r_a[0] ^ r_b[0] ^ r_br1;
    assign s_dbit2 = r_a[0] ^ r_b[0] ^ r_br2;
    assign s_bor1  = (~r_a[0] & r_b[0]) | (s_eq & r_br1);
    assign s_bor2  = (~r_b[0] & r_a[0]) | (s_eq & r_br2);

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.gcd_value = r_out;

    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        n_a         = r_a;
        n_b         = r_b;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~o_res.ready;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_br1       = r_br1;
        n_br2       = r_br2;
        n_nz        = r_nz;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_a     = r_run;
                    n_b     = i_in.value;
                    n_last  = i_in.last;
                    n_k     = '0;
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                // gcd(0,x) = x
                if (r_a == '0) begin
                    n_a     = r_b;
                    n_state = ST_SCALE;
                end else if (r_b == '0) begin
                    n_state = ST_SCALE;
                end else begin
                    n_state = ST_TWOS;
                end
            end
            ST_TWOS: begin
                if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = ST_STRIPA;
                end
            end
            ST_STRIPA: begin
                if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else begin
                    n_state = ST_STRIPB;
                end
            end
            ST_STRIPB: begin
                if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else begin
                    n_cnt   = '0;
                    n_br1   = 1'b0;
                    n_br2   = 1'b0;
                    n_nz    = 1'b0;
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                // operands rotate through their full width, back to their original value at the end of the pass
                n_a   = {r_a[0], r_a[VALUE_WIDTH-1:1]};
                n_b   = {r_b[0], r_b[VALUE_WIDTH-1:1]};
                n_d1  = {s_dbit1, r_d1[VALUE_WIDTH-1:1]};
                n_d2  = {s_dbit2, r_d2[VALUE_WIDTH-1:1]};
                n_br1 = s_bor1;
                n_br2 = s_bor2;
                n_nz  = r_nz | s_dbit1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt = '0;
                    if (!(r_nz | s_dbit1)) begin
                        n_state = ST_SCALE;
                    end else if (s_bor1) begin
                        n_b     = {s_dbit2, r_d2[VALUE_WIDTH-1:1]};
                        n_state = ST_STRIPB;
                    end else begin
                        n_a     = {s_dbit1, r_d1[VALUE_WIDTH-1:1]};
                        n_state = ST_STRIPA;
                    end
                end
            end
            ST_SCALE: begin
                if (r_k != '0) begin
                    n_a = r_a << 1;
                    n_k = r_k - 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_last) begin
                    n_run   = r_a;
                    n_state = ST_IDLE;
                end else if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_a;
                    n_run       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_d1   <= n_d1;
        r_d2   <= n_d2;
        r_out  <= n_out;
        r_last <= n_last;
        r_k    <= n_k;
        r_br1  <= n_br1;
        r_br2  <= n_br2;
        r_nz   <= n_nz;
    end

    // both operands odd when a subtract pass starts
    a_sub_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STRIPB && n_state == ST_SUB) |-> (r_a[0] && r_b[0]))
        else $error("subtract pass started with an even operand");

    // bit counter idles at zero outside the subtract pass
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SUB) |-> (r_cnt == '0))
        else $error("bit counter running outside subtract pass");

    // a taken result empties the output register unless a new one lands
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_res.ready && !(r_state == ST_DONE && r_last))
        |=> !r_out_valid)
        else $error("output register not emptied after transaction");

    // running gcd is cleared once a result is issued
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_last && n_state == ST_IDLE) |=> (r_run == '0))
        else $error("running gcd not cleared after last element");

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for array_gcd_reducer: streams arrays through the
// valid/ready input, stalling both channels at random except in the last
// phase, tracks the running gcd alongside the block, checks each array gcd.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import agr_pkg::*;

    localparam int unsigned W          = VALUE_WIDTH;
    localparam int          ELEM_CYCLES = 2 * W * (W + 3);
    localparam int          DRAIN_CYCLES = ELEM_CYCLES + 100;
    localparam int          WATCHDOG_LIMIT = 8 * ELEM_CYCLES + 1000;
    localparam int          ITEMS_PER_PHASE = 133;

    typedef logic [W-1:0] t_value;

    typedef struct packed {
        t_value value;
        logic   last;
    } t_elem;

    logic i_clk;
    logic i_rst_n;

    agr_in_if  #(.VALUE_WIDTH(W)) in_ch ();
    agr_out_if #(.VALUE_WIDTH(W)) res_ch ();

    array_gcd_reducer #(.VALUE_WIDTH(W)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    t_elem  pending_elems[$];
    t_value expected_gcds[$];
    t_value running_gcd;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     error_count;
    int     stall_cycles;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.last = 1'b0;
        res_ch.ready = 1'b0;
        running_gcd = '0;
        error_count = 0;
        stall_cycles = 0;
        send_idle_pct = 34;
        recv_idle_pct = 79;
    end

    always #5 i_clk = ~i_clk;

    function automatic t_value gcd_of(t_value a, t_value b);
        t_value r;
        while (b != '0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Fold one accepted element into the running gcd; close the array on last
    function automatic void fold_element(t_value v, logic is_last);
        running_gcd = gcd_of(running_gcd, v);
        if (is_last) begin
            expected_gcds.push_back(running_gcd);
            running_gcd = '0;
        end
    endfunction

    function automatic void push_elem(t_value v, logic is_last);
        t_elem e;
        e.value = v;
        e.last = is_last;
        pending_elems.push_back(e);
    endfunction

    function automatic t_value random_element(int mode, longint unsigned factor, int fw);
        t_value v;
        int     w;
        case (mode)
            0: v = t_value'($urandom());
            1: v = t_value'(factor * longint'($urandom_range(0, (32'd1 << (W - fw)) - 1)));
            2: v = t_value'($urandom_range(0, 255));
            3: v = t_value'($urandom_range(0, 15)) << $urandom_range(0, W - 4);
            default: begin
                w = $urandom_range(1, W);
                if ($urandom_range(2) == 0)
                    v = '0;
                else
                    v = t_value'($urandom() & ((64'd1 << w) - 1));
            end
        endcase
        return v;
    endfunction

    // Whole arrays, each with its own content style
    task automatic push_random_arrays(int target);
        int              count;
        int              len;
        int              mode;
        int              fw;
        longint unsigned factor;
        count = 0;
        while (count < target) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            mode = $urandom_range(0, 4);
            fw = $urandom_range(1, W - 1);
            factor = $urandom_range(1, (32'd1 << fw) - 1);
            for (int i = 0; i < len; i++)
                push_elem(random_element(mode, factor, fw), i == len - 1);
            count += len;
        end
    endtask

    task automatic push_directed();
        t_value max_v;
        max_v = '1;
        push_elem('0, 1'b1);                      // lone zero
        push_elem(max_v, 1'b1);                   // lone maximum
        push_elem(t_value'(1), 1'b1);
        push_elem('0, 1'b0);                      // all zeros
        push_elem('0, 1'b0);
        push_elem('0, 1'b1);
        push_elem('0, 1'b0);                      // zero first
        push_elem(t_value'(12), 1'b1);
        push_elem(max_v, 1'b0);
        push_elem(max_v - 1, 1'b1);
        push_elem(t_value'(1) << (W - 1), 1'b0);  // powers of two, top bit
        push_elem(t_value'(1) << 20, 1'b1);
        push_elem(t_value'(48), 1'b0);
        push_elem(t_value'(18), 1'b0);
        push_elem(t_value'(30), 1'b1);
        push_elem(t_value'(1000003), 1'b0);       // zero last
        push_elem('0, 1'b1);
        push_elem(t_value'(1), 1'b0);
        push_elem(max_v, 1'b1);
        push_elem(t_value'(64'h5555_5555), 1'b0); // alternating bit patterns
        push_elem(t_value'(64'h2AAA_AAAA), 1'b1);
    endtask

    // Input driver; the running gcd is updated on each accepted transaction
    always @(posedge i_clk) begin
        t_elem next_elem;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                fold_element(in_ch.value, in_ch.last);
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_elem = pending_elems.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.value <= next_elem.value;
                    in_ch.last <= next_elem.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver backpressure
    always @(posedge i_clk) begin
        t_value exp_gcd;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (res_ch.valid && res_ch.ready) begin
                if (expected_gcds.size() == 0) begin
                    $error("gcd_value: unexpected result 0x%08h, expected none",
                           res_ch.gcd_value);
                    error_count++;
                end else begin
                    exp_gcd = expected_gcds.pop_front();
                    if (res_ch.gcd_value !== exp_gcd) begin
                        $error("gcd_value mismatch: expected 0x%08h, actual 0x%08h",
                               exp_gcd, res_ch.gcd_value);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with work outstanding but no transaction on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (pending_elems.size() > 0 || in_ch.valid || expected_gcds.size() > 0) begin
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_directed();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 34;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            push_random_arrays(ITEMS_PER_PHASE);
            while (pending_elems.size() > 0) @(posedge i_clk);
        end

        while (pending_elems.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (expected_gcds.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_gcds.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
